### hdl/cms4_pkg.sv
// Package for the four-hash count-min sketch: constants, state enum, hash helpers.
// No dependencies.
`default_nettype none
package cms4_pkg;
  localparam int unsigned ROW_DEPTH_DEF   = 4096;
  localparam int unsigned COUNT_WIDTH_DEF = 32;
  localparam int unsigned ROW_SIZE_W      = 13;
  localparam int unsigned EST_W           = 32;
  localparam logic [63:0] DJB_SEED        = 64'd5381;
  localparam logic [12:0] ROW_SIZE_RESET  = 13'd4096;
  localparam logic [0:0]  REG_ROW_SIZE    = 1'b0;
  localparam logic [0:0]  KIND_STORE      = 1'b0;
  localparam logic [0:0]  KIND_QUERY      = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_MIX, ST_MOD, ST_READ, ST_WRITE, ST_OUT
  } state_t;

  // Update the one-at-a-time hash with one byte.
  function automatic logic [63:0] oaat_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] t;
    t = h + {56'd0, b};
    t = t + (t << 10);
    t = t ^ (t >> 6);
    return t;
  endfunction

  // Final avalanche of the one-at-a-time hash.
  function automatic logic [63:0] oaat_final(input logic [63:0] h);
    logic [63:0] t;
    t = h + (h << 3);
    t = t ^ (t >> 11);
    t = t + (t << 15);
    return t;
  endfunction
endpackage
`default_nettype wire

### hdl/cms4_if.sv
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`default_nettype none
interface cms4_if #(parameter int unsigned W = 1) (input wire logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/cms4_mod.sv
// Bit-serial modulo unit: reduces a 64-bit hash by a row size, one bit per cycle.
// No dependencies.
`default_nettype none
module cms4_mod #(
  parameter int unsigned NW = 21
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [63:0]   dividend,
  input  wire logic [NW-1:0] divisor,
  output logic               done,
  output logic [NW-1:0]      rem
);
  logic [63:0]   q_r;
  logic [NW:0]   rem_r;
  logic [6:0]    cnt_r;
  logic          busy_r;
  logic [NW:0]   shifted;
  logic [NW:0]   diff;

  assign shifted = {rem_r[NW-1:0], q_r[63]};
  assign diff    = shifted - {1'b0, divisor};

  // Shift one dividend bit in per cycle and subtract when it fits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 7'd0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 7'd1;
      if (cnt_r == 7'd63) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= {q_r[62:0], 1'b0};
      rem_r <= diff[NW] ? shifted : diff;
    end
  end

  assign done = busy_r && (cnt_r == 7'd63);
  assign rem  = rem_r[NW-1:0];
endmodule
`default_nettype wire

### hdl/count_min_sketch_four_hash_unit.sv
// Top level of the four-hash count-min sketch.
// After a byte with last is taken, the hashes are mixed, reduced in the four bit-serial
// modulo units run in parallel, the rows are read and then written, and the result is
// registered for output. No new byte is taken until the unit is idle again and the
// result has been taken. The pace between keys is set by the modulo units and the output.
// Reset: hashes reseed; a clearing pass writes zero to all ROW_DEPTH rows,
// while no item is accepted.
// Depends on cms4_pkg, cms4_if, cms4_mod.
`default_nettype none
module count_min_sketch_four_hash_unit #(
  parameter int unsigned ROW_DEPTH   = cms4_pkg::ROW_DEPTH_DEF,
  parameter int unsigned COUNT_WIDTH = cms4_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cms4_if.sink       in_ch,
  cms4_if.source     out_ch,
  input  wire logic  cfg_psel,
  input  wire logic  cfg_penable,
  input  wire logic  cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int unsigned AW = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
  localparam int unsigned NW = $clog2(ROW_DEPTH + 1);
  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

  // in_ch.data = {kind, key_byte, last}; out_ch.data = {was_query, estimate}
  logic       in_kind, in_last;
  logic [7:0] in_key_byte;
  assign in_kind     = in_ch.data[9];
  assign in_key_byte = in_ch.data[8:1];
  assign in_last     = in_ch.data[0];

  cms4_pkg::state_t state_r, state_nxt;

  logic [12:0] row_size_r;
  logic [63:0] djb_r, sdbm_r, oaat_r;
  logic [31:0] sum_r;
  logic        kind_r;
  logic [AW-1:0] clr_r;
  logic [NW-1:0] n_eff;
  logic [AW-1:0] pa, pb, pc, pd;
  logic [3:0]    mdone;
  logic [NW-1:0] ra, rb, rc, rd;
  logic          mstart;
  logic [COUNT_WIDTH-1:0] mem_a [ROW_DEPTH];
  logic [COUNT_WIDTH-1:0] mem_b [ROW_DEPTH];
  logic [COUNT_WIDTH-1:0] mem_c [ROW_DEPTH];
  logic [COUNT_WIDTH-1:0] mem_d [ROW_DEPTH];
  logic [COUNT_WIDTH-1:0] qa_r, qb_r, qc_r, qd_r;
  logic [COUNT_WIDTH-1:0] m1, m2, m3;
  logic [31:0]   est_r;
  logic          outq_r, out_valid_r;
  logic          in_xfer, mem_we;
  logic [AW-1:0] wa, wb, wc, wd;
  logic [COUNT_WIDTH-1:0] da, db, dc, dd;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {19'd0, row_size_r};
  always_ff @(posedge clk) begin
    if (!rst_n) row_size_r <= cms4_pkg::ROW_SIZE_RESET;
    else if (cfg_psel && cfg_penable && cfg_pwrite
             && cfg_paddr == {cms4_pkg::REG_ROW_SIZE, 2'b00})
      row_size_r <= cfg_pwdata[12:0];
  end

  // Clamp row size to 1..ROW_DEPTH
  always_comb begin
    if (row_size_r == 13'd0) n_eff = NW'(1);
    else if (32'(row_size_r) > ROW_DEPTH) n_eff = NW'(ROW_DEPTH);
    else n_eff = NW'(row_size_r);
  end

  assign in_ch.ready = (state_r == cms4_pkg::ST_IDLE) && !out_valid_r;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign mstart      = (state_r == cms4_pkg::ST_MIX);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cms4_pkg::ST_CLEAR: if (32'(clr_r) == ROW_DEPTH - 1) state_nxt = cms4_pkg::ST_IDLE;
      cms4_pkg::ST_IDLE:  if (in_xfer && in_last) state_nxt = cms4_pkg::ST_MIX;
      cms4_pkg::ST_MIX:   state_nxt = cms4_pkg::ST_MOD;
      cms4_pkg::ST_MOD:   if (mdone[0]) state_nxt = cms4_pkg::ST_READ;
      cms4_pkg::ST_READ:  state_nxt = cms4_pkg::ST_WRITE;
      cms4_pkg::ST_WRITE: state_nxt = cms4_pkg::ST_OUT;
      cms4_pkg::ST_OUT:   state_nxt = cms4_pkg::ST_IDLE;
      default:            state_nxt = cms4_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= cms4_pkg::ST_CLEAR;
    else state_r <= state_nxt;
  end

  // Clear sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (state_r == cms4_pkg::ST_CLEAR) clr_r <= clr_r + AW'(1);
  end

  // Running hashes: advance on nonzero bytes, finalize oaat, reseed after use
  always_ff @(posedge clk) begin
    if (!rst_n || state_r == cms4_pkg::ST_OUT) begin
      djb_r  <= cms4_pkg::DJB_SEED;
      sdbm_r <= '0;
      sum_r  <= '0;
      oaat_r <= '0;
    end else if (in_xfer && in_key_byte != 8'd0) begin
      djb_r  <= (djb_r << 5) + djb_r + {56'd0, in_key_byte};
      sdbm_r <= {56'd0, in_key_byte} + (sdbm_r << 6) + (sdbm_r << 16) - sdbm_r;
      sum_r  <= sum_r + {24'd0, in_key_byte};
      oaat_r <= cms4_pkg::oaat_step(oaat_r, in_key_byte);
    end
  end

  always_ff @(posedge clk) if (in_xfer) kind_r <= in_kind;

  // Four modulo units in parallel
  cms4_mod #(.NW(NW)) u_mod_a (.clk, .rst_n, .start(mstart), .dividend(djb_r),
    .divisor(n_eff), .done(mdone[0]), .rem(ra));
  cms4_mod #(.NW(NW)) u_mod_b (.clk, .rst_n, .start(mstart), .dividend(sdbm_r),
    .divisor(n_eff), .done(mdone[1]), .rem(rb));
  cms4_mod #(.NW(NW)) u_mod_c (.clk, .rst_n, .start(mstart), .dividend({32'd0, sum_r}),
    .divisor(n_eff), .done(mdone[2]), .rem(rc));
  cms4_mod #(.NW(NW)) u_mod_d (.clk, .rst_n, .start(mstart),
    .dividend(cms4_pkg::oaat_final(oaat_r)), .divisor(n_eff), .done(mdone[3]), .rem(rd));

  assign pa = ra[AW-1:0];
  assign pb = rb[AW-1:0];
  assign pc = rc[AW-1:0];
  assign pd = rd[AW-1:0];

  // Memory write side: clear sweep or saturating increment
  assign mem_we = (state_r == cms4_pkg::ST_CLEAR) ||
                  (state_r == cms4_pkg::ST_WRITE && kind_r == cms4_pkg::KIND_STORE);
  always_comb begin
    if (state_r == cms4_pkg::ST_CLEAR) begin
      wa = clr_r; wb = clr_r; wc = clr_r; wd = clr_r;
      da = '0; db = '0; dc = '0; dd = '0;
    end else begin
      wa = pa; wb = pb; wc = pc; wd = pd;
      da = (qa_r == CMAX) ? qa_r : qa_r + COUNT_WIDTH'(1);
      db = (qb_r == CMAX) ? qb_r : qb_r + COUNT_WIDTH'(1);
      dc = (qc_r == CMAX) ? qc_r : qc_r + COUNT_WIDTH'(1);
      dd = (qd_r == CMAX) ? qd_r : qd_r + COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_a[wa] <= da;
      mem_b[wb] <= db;
      mem_c[wc] <= dc;
      mem_d[wd] <= dd;
    end
  end

  // Registered reads
  always_ff @(posedge clk) begin
    qa_r <= mem_a[pa];
    qb_r <= mem_b[pb];
    qc_r <= mem_c[pc];
    qd_r <= mem_d[pd];
  end

  // Minimum of four, saturated to the estimate width
  assign m1 = (qb_r < qa_r) ? qb_r : qa_r;
  assign m2 = (qc_r < m1) ? qc_r : m1;
  assign m3 = (qd_r < m2) ? qd_r : m2;

  always_ff @(posedge clk) begin
    if (state_r == cms4_pkg::ST_WRITE) begin
      outq_r <= kind_r;
      if (kind_r == cms4_pkg::KIND_STORE) est_r <= '0;
      else if (COUNT_WIDTH > 32 && (m3 >> (COUNT_WIDTH > 32 ? 32 : 0)) != '0)
        est_r <= '1;
      else est_r <= 32'(m3);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (state_r == cms4_pkg::ST_WRITE) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = {outq_r, est_r};

  // Checks
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != cms4_pkg::ST_IDLE |-> !in_ch.ready)
    else $error("input ready outside idle");
  a_mod_sync: assert property (@(posedge clk) disable iff (!rst_n)
    mdone[0] |-> mdone[3] && mdone[1] && mdone[2])
    else $error("modulo units out of step");
  a_out_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == cms4_pkg::ST_WRITE)
    else $error("result without table access");
endmodule
`default_nettype wire
